/* design/esc_pkg.sv */
package esc_pkg;

	// Default epoch: midnight, January 1 1970, which was a Thursday.
	localparam int EPOCH_BASE_YEAR_DEF     = 1970;
	localparam int EPOCH_FIRST_WEEKDAY_DEF = 4;

	// Field widths of the input item and of the result item.
	localparam int EPOCH_W = 32;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 16;
	localparam int MON_W   = 4;
	localparam int YOFF_W  = 8;
	localparam int WDAY_W  = 3;
	localparam int YDAY_W  = 9;

	// Width of the reciprocal product.
	localparam int PROD_W = 2 * EPOCH_W;

	// Divisors of the time split and of the weekday.
	localparam logic [5:0] SECS_PER_MIN  = 6'd60;
	localparam logic [5:0] MINS_PER_HOUR = 6'd60;
	localparam logic [5:0] HOURS_PER_DAY = 6'd24;
	localparam logic [5:0] DAYS_PER_WEEK = 6'd7;

	// Rounded-up reciprocals of the divisors. For every dividend that a pass can see
	// (32 bits of seconds, 27 bits of minutes, 21 bits of hours, 16 bits of days plus
	// the weekday offset), x / d equals (x * RECIP) >> SHIFT exactly.
	localparam logic [EPOCH_W-1:0] SEC_RECIP  = 32'h8888_8889;
	localparam logic [EPOCH_W-1:0] MIN_RECIP  = 32'h8888_8889;
	localparam logic [EPOCH_W-1:0] HOUR_RECIP = 32'h0AAA_AAAB;
	localparam logic [EPOCH_W-1:0] WDAY_RECIP = 32'h2492_4925;
	localparam int SEC_SHIFT  = 37;
	localparam int MIN_SHIFT  = 37;
	localparam int HOUR_SHIFT = 32;
	localparam int WDAY_SHIFT = 32;

	localparam logic [MON_W-1:0] MON_FEBRUARY = 4'd1;
	localparam logic [MON_W-1:0] MON_DECEMBER = 4'd11;

	localparam logic [DAY_W-1:0] DAYS_COMMON_YEAR = 16'd365;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} esc_state_t;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_HOUR,
		PH_WDAY
	} esc_phase_t;

	// Length of a month in a common year.
	function automatic logic [4:0] month_len(input logic [MON_W-1:0] mon);
		logic [4:0] len;
		begin
			unique case (mon)
				4'd1: len = 5'd28;
				4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

/* design/esc_item_if.sv */
interface esc_item_if import esc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_seconds;
	logic               elapsed_mode;

	modport source (output valid, output epoch_seconds, output elapsed_mode, input ready);
	modport sink (input valid, input epoch_seconds, input elapsed_mode, output ready);
endinterface

/* design/esc_result_if.sv */
interface esc_result_if import esc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SEC_W-1:0]  second_of_minute;
	logic [MIN_W-1:0]  minute_of_hour;
	logic [HOUR_W-1:0] hour_of_day;
	logic [DAY_W-1:0]  day_field;
	logic [MON_W-1:0]  month_index;
	logic [YOFF_W-1:0] year_offset;
	logic [WDAY_W-1:0] weekday;
	logic [YDAY_W-1:0] day_of_year;

	modport source (
		output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
		output day_field, output month_index, output year_offset, output weekday,
		output day_of_year, input ready
	);
	modport sink (
		input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
		input day_field, input month_index, input year_offset, input weekday,
		input day_of_year, output ready
	);
endinterface

/* design/epoch_seconds_to_calendar_top.sv */
// Converts a 32-bit count of seconds since midnight, January 1 of EPOCH_BASE_YEAR, into
// calendar fields. Input items arrive on the item channel (epoch_seconds, elapsed_mode);
// each one gives exactly one transfer on the result channel. With elapsed_mode set, the
// day field carries the whole elapsed day count and month, year, weekday and day of year
// are zero.
// A small sequencer reuses one multiplier and one subtractor. Each division, by 60, 60
// and 24 and then by 7 for the weekday, is a registered multiply by the divisor's
// reciprocal, then the remainder by subtraction. After that one year is removed per
// cycle and one month per cycle. In elapsed mode the sequencer stops after the
// division by 24 and skips the weekday, year and month steps.
// The block takes one item at a time: item.ready is high only while the sequencer idles.
// The result sits in an output register, so the next item is taken while a finished
// result still waits. If the receiver stalls, the result is held unchanged, and a second
// finished item waits in the sequencer until the output register frees up.
// Reset (arst_n low) empties the output register and returns the sequencer to idle.
module epoch_seconds_to_calendar_top import esc_pkg::*; #(
	parameter int EPOCH_BASE_YEAR     = EPOCH_BASE_YEAR_DEF,
	parameter int EPOCH_FIRST_WEEKDAY = EPOCH_FIRST_WEEKDAY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	esc_item_if.sink     item,
	esc_result_if.source result
);

	// Position of the base year in the 4, 100 and 400 year leap cycles. The year loop
	// advances these counters instead of dividing the year.
	localparam logic [1:0] BASE_MOD4   = 2'(EPOCH_BASE_YEAR % 4);
	localparam logic [6:0] BASE_MOD100 = 7'(EPOCH_BASE_YEAR % 100);
	localparam logic [8:0] BASE_MOD400 = 9'(EPOCH_BASE_YEAR % 400);

	esc_state_t state_q, state_d;
	esc_phase_t phase_q;

	logic               step_q;
	logic [EPOCH_W-1:0] dvd_q;
	logic [PROD_W-1:0]  prod_q;
	logic               elapsed_q;

	logic [SEC_W-1:0]  sec_q;
	logic [MIN_W-1:0]  min_q;
	logic [HOUR_W-1:0] hour_q;
	logic [DAY_W-1:0]  days_q;
	logic [WDAY_W-1:0] wday_q;
	logic [YOFF_W-1:0] yoff_q;
	logic [YDAY_W-1:0] yday_q;
	logic [MON_W-1:0]  mon_q;
	logic [1:0]        y4_q;
	logic [6:0]        y100_q;
	logic [8:0]        y400_q;

	// Output register.
	logic              res_valid_q;
	logic [SEC_W-1:0]  res_sec_q;
	logic [MIN_W-1:0]  res_min_q;
	logic [HOUR_W-1:0] res_hour_q;
	logic [DAY_W-1:0]  res_day_q;
	logic [MON_W-1:0]  res_mon_q;
	logic [YOFF_W-1:0] res_yoff_q;
	logic [WDAY_W-1:0] res_wday_q;
	logic [YDAY_W-1:0] res_yday_q;

	// Shared compare-and-subtract unit.
	logic [EPOCH_W-1:0] opa, opb;
	logic [EPOCH_W:0]   diff;
	logic               ge;

	logic               accept;
	logic               out_free;
	logic               load_res;
	logic               div_last;
	logic [EPOCH_W-1:0] recip;
	logic [EPOCH_W-1:0] quo;
	logic [EPOCH_W-1:0] quo_times_d;
	logic [PROD_W-1:0]  product;
	logic               leap;
	logic               month_step;

	assign diff = {1'b0, opa} - {1'b0, opb};
	assign ge   = ~diff[EPOCH_W];

	// The current year is a leap year by the Gregorian 4/100/400 rule.
	assign leap = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));

	// Division by a constant: a pass first registers the dividend times the reciprocal,
	// then takes the quotient from the top of that product and gets the remainder as
	// dividend minus quotient times divisor.
	always_comb begin
		unique case (phase_q)
			PH_SEC: begin
				recip       = SEC_RECIP;
				quo         = EPOCH_W'(prod_q >> SEC_SHIFT);
				quo_times_d = quo * EPOCH_W'(SECS_PER_MIN);
			end
			PH_MIN: begin
				recip       = MIN_RECIP;
				quo         = EPOCH_W'(prod_q >> MIN_SHIFT);
				quo_times_d = quo * EPOCH_W'(MINS_PER_HOUR);
			end
			PH_HOUR: begin
				recip       = HOUR_RECIP;
				quo         = EPOCH_W'(prod_q >> HOUR_SHIFT);
				quo_times_d = quo * EPOCH_W'(HOURS_PER_DAY);
			end
			default: begin
				recip       = WDAY_RECIP;
				quo         = EPOCH_W'(prod_q >> WDAY_SHIFT);
				quo_times_d = quo * EPOCH_W'(DAYS_PER_WEEK);
			end
		endcase
	end

	assign product  = {{EPOCH_W{1'b0}}, dvd_q} * {{EPOCH_W{1'b0}}, recip};
	assign div_last = step_q;

	// Handshake and operand selection.
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		out_free   = !res_valid_q || result.ready;
		load_res   = (state_q == ST_DONE) && out_free;
		month_step = ge && (mon_q != MON_DECEMBER);
		unique case (state_q)
			ST_DIV: begin
				opa = dvd_q;
				opb = quo_times_d;
			end
			ST_YEAR: begin
				opa = EPOCH_W'(days_q);
				opb = EPOCH_W'(DAYS_COMMON_YEAR) + EPOCH_W'(leap);
			end
			ST_MONTH: begin
				opa = EPOCH_W'(days_q);
				opb = EPOCH_W'(month_len(mon_q)) + EPOCH_W'(leap && (mon_q == MON_FEBRUARY));
			end
			default: begin
				opa = EPOCH_W'(days_q);
				opb = '0;
			end
		endcase
	end

	assign accept = item.valid && item.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last && (phase_q == PH_HOUR) && elapsed_q) state_d = ST_DONE;
				else if (div_last && (phase_q == PH_WDAY)) state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (!ge) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				if (!month_step) state_d = ST_DONE;
			end
			default: begin
				if (out_free) state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SEC;
			step_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q <= PH_SEC;
				step_q  <= 1'b0;
			end else if (state_q == ST_DIV) begin
				if (div_last) begin
					step_q <= 1'b0;
					unique case (phase_q)
						PH_SEC:  phase_q <= PH_MIN;
						PH_MIN:  phase_q <= PH_HOUR;
						PH_HOUR: phase_q <= PH_WDAY;
						default: phase_q <= PH_SEC;
					endcase
				end else begin
					step_q <= 1'b1;
				end
			end
			if (load_res) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q     <= item.epoch_seconds;
			elapsed_q <= item.elapsed_mode;
			mon_q     <= '0;
			yoff_q    <= '0;
			wday_q    <= '0;
			yday_q    <= '0;
		end
		unique case (state_q)
			ST_DIV: begin
				if (!div_last) begin
					prod_q <= product;
				end else begin
					unique case (phase_q)
						PH_SEC: begin
							sec_q <= diff[SEC_W-1:0];
							dvd_q <= quo;
						end
						PH_MIN: begin
							min_q <= diff[MIN_W-1:0];
							dvd_q <= quo;
						end
						PH_HOUR: begin
							hour_q <= diff[HOUR_W-1:0];
							days_q <= quo[DAY_W-1:0];
							// The weekday pass divides the day count, offset by the
							// weekday of the first epoch day, by seven.
							dvd_q  <= EPOCH_W'(quo[DAY_W-1:0]) + EPOCH_W'(EPOCH_FIRST_WEEKDAY);
						end
						default: begin
							wday_q <= diff[WDAY_W-1:0];
							y4_q   <= BASE_MOD4;
							y100_q <= BASE_MOD100;
							y400_q <= BASE_MOD400;
						end
					endcase
				end
			end
			ST_YEAR: begin
				if (ge) begin
					days_q <= diff[DAY_W-1:0];
					yoff_q <= yoff_q + 1'b1;
					y4_q   <= y4_q + 1'b1;
					y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 1'b1;
					y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 1'b1;
				end else begin
					yday_q <= days_q[YDAY_W-1:0];
				end
			end
			ST_MONTH: begin
				if (month_step) begin
					days_q <= diff[DAY_W-1:0];
					mon_q  <= mon_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_sec_q  <= sec_q;
			res_min_q  <= min_q;
			res_hour_q <= hour_q;
			res_day_q  <= elapsed_q ? days_q : days_q + 1'b1;
			res_mon_q  <= mon_q;
			res_yoff_q <= yoff_q;
			res_wday_q <= wday_q;
			res_yday_q <= yday_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.second_of_minute = res_sec_q;
	assign result.minute_of_hour   = res_min_q;
	assign result.hour_of_day      = res_hour_q;
	assign result.day_field        = res_day_q;
	assign result.month_index      = res_mon_q;
	assign result.year_offset      = res_yoff_q;
	assign result.weekday          = res_wday_q;
	assign result.day_of_year      = res_yday_q;

endmodule
